[rtl/core/deq_pkg.sv]
// package for the double-ended queue: sizes, command and status codes,
// controller states and the controller/datapath interface structs
// no dependencies
`default_nettype none

package deq_pkg;

	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int SUM_W      = ADDR_W + 1;

	localparam int CMD_W      = 3;
	localparam int ST_W       = 2;
	localparam int IN_W       = ((CMD_W + DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_BITS   = DATA_WIDTH + CNT_W + ST_W;
	localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5,
		CMD_CLEAR      = 3'd6,
		CMD_NONE       = 3'd7
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic exec;
		cmd_t op;
		logic reject;
		logic cap_rd;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
	} dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/deq_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/deq_ctrl.sv]
// controller state machine of the double-ended queue
// depends on deq_pkg
`default_nettype none

module deq_ctrl import deq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire cmd_t     op_in,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	input  wire dp_stat_t dp_stat,
	output ctrl_t         ctrl
);

	state_t state_q;
	state_t state_nxt;
	logic   accept;
	logic   is_read;
	logic   is_push;
	logic   reject;

	// command decode
	always_comb begin
		is_read = 1'b0;
		is_push = 1'b0;
		case (op_in) inside
			CMD_PUSH_FRONT, CMD_PUSH_BACK: is_push = 1'b1;
			CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: is_read = 1'b1;
			default: ;
		endcase
	end

	assign reject   = (is_read && dp_stat.empty) || (is_push && dp_stat.full);
	assign s_tready = (state_q == S_IDLE) || ((state_q == S_RESP) && m_tready);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE, S_RESP: begin
				if (accept) begin
					state_nxt = (is_read && !reject) ? S_READ : S_RESP;
				end else if ((state_q == S_RESP) && m_tready) begin
					state_nxt = S_IDLE;
				end
			end
			S_READ: state_nxt = S_RESP;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl.exec   = accept;
		ctrl.op     = op_in;
		ctrl.reject = reject;
		ctrl.cap_rd = 1'b0;
		m_tvalid    = 1'b0;
		unique case (state_q)
			S_IDLE: ;
			S_READ: ctrl.cap_rd = 1'b1;
			S_RESP: m_tvalid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/core/deq_dp.sv]
// datapath of the double-ended queue: head pointer, count, ring store
// and result register; depends on deq_pkg and deq_ram
`default_nettype none

module deq_dp import deq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctrl_t                 ctrl,
	input  wire logic [DATA_WIDTH-1:0] push_value,
	output dp_stat_t                   dp_stat,
	output logic      [DATA_WIDTH-1:0] read_value,
	output logic      [CNT_W-1:0]      element_count,
	output stat_t                      status
);

	logic [ADDR_W-1:0]     head_q;
	logic [CNT_W-1:0]      count_q;
	logic [DATA_WIDTH-1:0] rv_q;
	logic [CNT_W-1:0]      cnt_out_q;
	stat_t                 stat_q;

	logic [ADDR_W-1:0]     head_dec;
	logic [ADDR_W-1:0]     head_inc;
	logic [ADDR_W-1:0]     tail_slot;
	logic [ADDR_W-1:0]     back_slot;
	logic [ADDR_W-1:0]     head_nxt;
	logic [CNT_W-1:0]      count_nxt;
	stat_t                 stat_nxt;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic                  ram_re;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	function automatic logic [ADDR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
		return r[ADDR_W-1:0];
	endfunction

	assign dp_stat.empty = (count_q == '0);
	assign dp_stat.full  = (count_q >= CNT_W'(DEPTH));

	assign head_dec  = (head_q == '0) ? ADDR_W'(DEPTH - 1) : (head_q - ADDR_W'(1));
	assign head_inc  = ring_wrap(SUM_W'(head_q) + SUM_W'(1));
	assign tail_slot = ring_wrap(SUM_W'(head_q) + SUM_W'(count_q));
	assign back_slot = ring_wrap(SUM_W'(head_q) + SUM_W'(count_q) - SUM_W'(1));

	always_comb begin
		head_nxt  = head_q;
		count_nxt = count_q;
		stat_nxt  = STAT_OK;
		ram_we    = 1'b0;
		ram_waddr = tail_slot;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		if (ctrl.reject) begin
			stat_nxt = dp_stat.empty ? STAT_EMPTY : STAT_FULL;
			if ((ctrl.op == CMD_PUSH_FRONT) || (ctrl.op == CMD_PUSH_BACK)) begin
				stat_nxt = STAT_FULL;
			end
		end else begin
			case (ctrl.op)
				CMD_PUSH_FRONT: begin
					head_nxt  = head_dec;
					count_nxt = count_q + CNT_W'(1);
					ram_we    = 1'b1;
					ram_waddr = head_dec;
				end
				CMD_PUSH_BACK: begin
					count_nxt = count_q + CNT_W'(1);
					ram_we    = 1'b1;
					ram_waddr = tail_slot;
				end
				CMD_POP_FRONT: begin
					head_nxt  = head_inc;
					count_nxt = count_q - CNT_W'(1);
					ram_re    = 1'b1;
					ram_raddr = head_q;
				end
				CMD_POP_BACK: begin
					count_nxt = count_q - CNT_W'(1);
					ram_re    = 1'b1;
					ram_raddr = back_slot;
				end
				CMD_PEEK_FRONT: begin
					ram_re    = 1'b1;
					ram_raddr = head_q;
				end
				CMD_PEEK_BACK: begin
					ram_re    = 1'b1;
					ram_raddr = back_slot;
				end
				CMD_CLEAR: begin
					head_nxt  = '0;
					count_nxt = '0;
				end
				default: ;
			endcase
		end
	end

	deq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctrl.exec && ram_we),
		.waddr(ram_waddr),
		.wdata(push_value),
		.re   (ctrl.exec && ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctrl.exec) begin
			head_q  <= head_nxt;
			count_q <= count_nxt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			rv_q      <= '0;
			cnt_out_q <= count_nxt;
			stat_q    <= stat_nxt;
		end else if (ctrl.cap_rd) begin
			rv_q <= ram_rdata;
		end
	end

	assign read_value    = rv_q;
	assign element_count = cnt_out_q;
	assign status        = stat_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count above depth");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.exec && (ctrl.op == CMD_CLEAR)) |=> ((count_q == '0) && (head_q == '0)))
		else $error("clear did not reset pointers");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.exec && !ctrl.reject && ((ctrl.op == CMD_POP_FRONT) || (ctrl.op == CMD_POP_BACK)))
		|=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("pop did not decrement count");

	a_no_cap_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.exec && ctrl.cap_rd))
		else $error("read capture overlaps a new command");

endmodule

`default_nettype wire

[rtl/core/double_ended_queue.sv]
// top level of the bounded double-ended queue: controller, datapath, ring ram
// depends on deq_pkg, deq_ctrl, deq_dp, deq_ram
//
// channel   dir  fields (low bit up)
// s_*       in   command[2:0], push_value[34:3], zero pad to 40 bits
// m_*       out  read_value[31:0], element_count[40:32], status[42:41], zero pad to 48
//
// pushes, clear, no-op and rejected commands: the result register is loaded as the beat is taken
// pops and peeks: the registered read data of the ring ram is captured into the result register in S_READ
// a new beat is taken while idle, or in the cycle the pending result is taken
// reset clears head pointer, count and controller; ram contents are not cleared
`default_nettype none

module double_ended_queue import deq_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,   // command, push_value
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [OUT_W-1:0] m_tdata    // read_value, element_count, status
);

	ctrl_t                 ctrl;
	dp_stat_t              dp_stat;
	cmd_t                  op_in;
	logic [DATA_WIDTH-1:0] read_value;
	logic [CNT_W-1:0]      element_count;
	stat_t                 status;

	assign op_in = cmd_t'(s_tdata[CMD_W-1:0]);

	deq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.op_in   (op_in),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.dp_stat (dp_stat),
		.ctrl    (ctrl)
	);

	deq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.push_value   (s_tdata[CMD_W +: DATA_WIDTH]),
		.dp_stat      (dp_stat),
		.read_value   (read_value),
		.element_count(element_count),
		.status       (status)
	);

	assign m_tdata = OUT_W'({status, element_count, read_value});

endmodule

`default_nettype wire

[tb/tb.sv]
// self-checking testbench for double_ended_queue: command beats in, result beats out
// a scoreboard class predicts each result from its own ring copy and checks it
// depends on deq_pkg and the double_ended_queue rtl
module tb import deq_pkg::*;;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] read_value;
		logic [CNT_W-1:0]      element_count;
		stat_t                 status;
	} deq_result_t;

	class deque_scoreboard;
		logic [DATA_WIDTH-1:0] ring [DEPTH];
		int                    head;
		int                    count;
		deq_result_t           expected_q [$];
		int                    errors;

		function new();
			head   = 0;
			count  = 0;
			errors = 0;
		endfunction

		function void note_command(cmd_t op, logic [DATA_WIDTH-1:0] value);
			deq_result_t res;
			int          slot;
			res.read_value = '0;
			res.status     = STAT_OK;
			case (op)
				CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
					if (count >= DEPTH) begin
						res.status = STAT_FULL;
					end else if (op == CMD_PUSH_FRONT) begin
						head       = (head == 0) ? DEPTH - 1 : head - 1;
						ring[head] = value;
						count++;
					end else begin
						ring[(head + count) % DEPTH] = value;
						count++;
					end
				end
				CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
					if (count == 0) begin
						res.status = STAT_EMPTY;
					end else begin
						if (op == CMD_POP_FRONT || op == CMD_PEEK_FRONT)
							slot = head;
						else
							slot = (head + count - 1) % DEPTH;
						res.read_value = ring[slot];
						if (op == CMD_POP_FRONT) begin
							head = (head + 1) % DEPTH;
							count--;
						end else if (op == CMD_POP_BACK) begin
							count--;
						end
					end
				end
				CMD_CLEAR: begin
					head  = 0;
					count = 0;
				end
				default: ;
			endcase
			res.element_count = CNT_W'(count);
			expected_q.push_back(res);
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			deq_result_t exp_res;
			deq_result_t act_res;
			act_res.read_value    = data[DATA_WIDTH-1:0];
			act_res.element_count = data[DATA_WIDTH +: CNT_W];
			act_res.status        = stat_t'(data[DATA_WIDTH+CNT_W +: ST_W]);
			if (expected_q.size() == 0) begin
				$display("%0t: result beat with none expected, actual %h", $time, data);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (act_res.read_value !== exp_res.read_value) begin
				$display("%0t: read_value mismatch, expected %h actual %h",
					$time, exp_res.read_value, act_res.read_value);
				errors++;
			end
			if (act_res.element_count !== exp_res.element_count) begin
				$display("%0t: element_count mismatch, expected %0d actual %0d",
					$time, exp_res.element_count, act_res.element_count);
				errors++;
			end
			if (act_res.status !== exp_res.status) begin
				$display("%0t: status mismatch, expected %0d actual %0d",
					$time, exp_res.status, act_res.status);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;
	int               cycle_count = 0;
	deque_scoreboard  book;

	double_ended_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.check_result(m_tdata);
	end

	task automatic send_command(input cmd_t op, input logic [DATA_WIDTH-1:0] value);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W-CMD_W-DATA_WIDTH){1'b0}}, value, op};
		do @(posedge clk); while (!s_tready);
		book.note_command(op, value);
		@(negedge clk);
	endtask

	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (book.expected_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_directed();
		send_command(CMD_POP_FRONT, 32'hFFFF_FFFF);
		send_command(CMD_POP_BACK, 32'h0);
		send_command(CMD_PEEK_FRONT, 32'h0);
		send_command(CMD_PEEK_BACK, 32'hFFFF_FFFF);
		send_command(CMD_PUSH_BACK, 32'h0);
		send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
		send_command(CMD_PUSH_BACK, 32'hA5A5_A5A5);
		send_command(CMD_PUSH_FRONT, 32'h5A5A_5A5A);
		send_command(CMD_PEEK_FRONT, 32'h1234_5678);
		send_command(CMD_PEEK_BACK, 32'h0);
		send_command(CMD_POP_FRONT, 32'h0);
		send_command(CMD_POP_BACK, 32'h0);
		send_command(CMD_PEEK_FRONT, 32'h0);
		send_command(CMD_PEEK_BACK, 32'h0);
		send_command(CMD_NONE, 32'hDEAD_BEEF);
		send_command(CMD_PUSH_BACK, 32'h1234_5678);
		send_command(CMD_CLEAR, 32'hFFFF_FFFF);
		send_command(CMD_POP_FRONT, 32'h0);
		// head wraps below zero right after clear
		send_command(CMD_PUSH_FRONT, 32'h0000_0001);
		send_command(CMD_PUSH_FRONT, 32'h8000_0000);
		send_command(CMD_PEEK_BACK, 32'h0);
		send_command(CMD_POP_BACK, 32'h0);
		send_command(CMD_POP_BACK, 32'h0);
		send_command(CMD_PEEK_FRONT, 32'h0);
	endtask

	task automatic fill_and_drain();
		while (book.count < DEPTH)
			send_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
		repeat (4)
			send_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
		send_command(CMD_PEEK_FRONT, $urandom);
		send_command(CMD_PEEK_BACK, $urandom);
		while (book.count > 0)
			send_command(cmd_t'(CMD_W'($urandom_range(2, 3))), $urandom);
		send_command(CMD_POP_FRONT, $urandom);
		send_command(CMD_POP_BACK, $urandom);
	endtask

	task automatic run_random(input int n_items);
		int   push_pct;
		cmd_t op;
		push_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			if (i % 25 == 0)
				push_pct = $urandom_range(20, 80);
			if ($urandom_range(0, 24) == 0)
				op = $urandom_range(0, 1) ? CMD_CLEAR : CMD_NONE;
			else if ($urandom_range(0, 99) < push_pct)
				op = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
			else
				op = cmd_t'(CMD_W'($urandom_range(2, 5)));
			send_command(op, $urandom);
		end
	endtask

	initial begin
		book = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		fill_and_drain();
		run_random(60);
		wait_results_done();

		send_idle_pct  = 88;
		recv_stall_pct = 0;
		run_random(100);
		wait_results_done();

		send_idle_pct  = 0;
		recv_stall_pct = 88;
		run_random(100);
		wait_results_done();

		send_idle_pct  = 30;
		recv_stall_pct = 30;
		run_random(100);
		wait_results_done();

		repeat (8) @(posedge clk);
		if (book.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
